// ----- src/olbp_pkg.sv -----
package olbp_pkg;

   localparam int PIXEL_W = 8;
   localparam int CODE_W = 4;
   localparam int BIN_W = 5;
   localparam int COUNT_W = 23;
   localparam int TOTAL_W = 24;
   localparam int BIN_COUNT = 32;
   localparam int HALF_BINS = 16;

   localparam int IMAGE_WIDTH_W = 12;
   localparam int IMAGE_HEIGHT_W = 13;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_INDEX_W = 1;

   localparam int MAX_WIDTH_DEFAULT = 2048;
   localparam int MAX_HEIGHT_DEFAULT = 4096;
   localparam int IMAGE_WIDTH_RESET = 640;
   localparam int IMAGE_HEIGHT_RESET = 480;
   localparam int MIN_SIZE = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic              upd;
      logic              last;
      logic [CODE_W-1:0] orth;
      logic [CODE_W-1:0] diag;
   } hist_op_type;

   typedef enum logic [0:0] {
      BK_RUN,
      BK_DRAIN
   } back_state_type;

endpackage

// ----- src/olbp_front.sv -----
module olbp_front
   import olbp_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT,
   localparam int COL_W = $clog2(MAX_WIDTH),
   localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_i,
   input  logic [PIXEL_W-1:0] pixel_i,
   input  logic [COL_W-1:0]   w_last_i,
   input  logic [ROW_W-1:0]   h_last_i,
   input  logic [QCNT_W-1:0]  q_count_i,
   output logic               full_o,
   output logic               q_push_o,
   output hist_op_type        q_op_o
);

   logic [2*PIXEL_W-1:0] line_mem [MAX_WIDTH];

   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic                 vb_ff;
   logic [PIXEL_W-1:0]   px_b_ff;
   logic [COL_W-1:0]     col_b_ff;
   logic                 int_b_ff;
   logic                 end_b_ff;
   logic [2*PIXEL_W-1:0] rd_ff;
   logic [PIXEL_W-1:0]   win_ff [9];
   logic [PIXEL_W-1:0]   win_in [9];
   logic                 accept;
   logic                 interior;
   logic                 row_end;
   logic                 frame_end;
   logic [QCNT_W:0]      backlog;

   assign backlog = {1'b0, q_count_i} + {{QCNT_W{1'b0}}, vb_ff};
   assign full_o = backlog >= (QCNT_W+1)'(QUEUE_DEPTH);
   assign accept = push_i && !full_o;

   always_comb begin
      interior = (col_ff >= COL_W'(2)) && (row_ff >= ROW_W'(2));
      row_end = col_ff >= w_last_i;
      frame_end = row_end && (row_ff >= h_last_i);
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         vb_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         vb_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= line_mem[col_ff];
      if (vb_ff) begin
         line_mem[col_b_ff] <= {rd_ff[PIXEL_W-1:0], px_b_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_b_ff <= pixel_i;
         col_b_ff <= col_ff;
         int_b_ff <= interior;
         end_b_ff <= frame_end;
      end
   end

   always_comb begin
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = rd_ff[2*PIXEL_W-1:PIXEL_W];
      win_in[3] = win_ff[4];
      win_in[4] = win_ff[5];
      win_in[5] = rd_ff[PIXEL_W-1:0];
      win_in[6] = win_ff[7];
      win_in[7] = win_ff[8];
      win_in[8] = px_b_ff;
   end

   always_ff @(posedge clock) begin
      if (vb_ff) begin
         win_ff <= win_in;
      end
   end

   always_comb begin
      q_push_o = vb_ff;
      q_op_o.upd = int_b_ff;
      q_op_o.last = end_b_ff;
      q_op_o.orth = {win_in[1] > win_in[4], win_in[3] > win_in[4],
                     win_in[7] > win_in[4], win_in[5] > win_in[4]};
      q_op_o.diag = {win_in[2] > win_in[4], win_in[0] > win_in[4],
                     win_in[6] > win_in[4], win_in[8] > win_in[4]};
   end

endmodule

// ----- src/olbp_queue.sv -----
module olbp_queue
   import olbp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push_i,
   input  hist_op_type       op_i,
   input  logic              pop_i,
   output hist_op_type       op_o,
   output logic              empty_o,
   output logic [QCNT_W-1:0] count_o
);

   hist_op_type       entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign empty_o = count_ff == '0;
   assign count_o = count_ff;
   assign op_o = entries_ff[rd_ptr_ff];
   assign do_pop = pop_i && !empty_o;

   always_comb begin
      wr_ptr_in = push_i ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + QCNT_W'(push_i) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         entries_ff[wr_ptr_ff] <= op_i;
      end
   end

endmodule

// ----- src/olbp_back.sv -----
module olbp_back
   import olbp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  hist_op_type        q_op_i,
   input  logic               q_empty_i,
   output logic               q_pop_o,
   input  logic               rsp_pop_i,
   output logic               rsp_valid_o,
   output logic [BIN_W-1:0]   rsp_bin_o,
   output logic [COUNT_W-1:0] rsp_count_o,
   output logic [TOTAL_W-1:0] rsp_total_o,
   output logic               rsp_last_o
);

   back_state_type     state_ff, state_in;
   logic [COUNT_W-1:0] bins_ff [BIN_COUNT];
   logic [COUNT_W-1:0] bins_in [BIN_COUNT];
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [BIN_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BIN_W-1:0]   rsp_bin_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic               rsp_last_ff;
   logic               load;
   logic               clear;
   logic               inc;

   always_comb begin
      state_in = state_ff;
      q_pop_o = 1'b0;
      load = 1'b0;
      clear = 1'b0;
      case (state_ff)
         BK_RUN: begin
            q_pop_o = !q_empty_i;
            if (q_pop_o && q_op_i.last) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            load = !rsp_valid_ff || rsp_pop_i;
            if (load && rd_idx_ff == BIN_W'(BIN_COUNT - 1)) begin
               clear = 1'b1;
               state_in = BK_RUN;
            end
         end
         default: begin
            state_in = BK_RUN;
         end
      endcase
   end

   assign inc = q_pop_o && q_op_i.upd;

   always_comb begin
      for (int i = 0; i < BIN_COUNT; i++) begin
         bins_in[i] = bins_ff[i];
         if (clear) begin
            bins_in[i] = '0;
         end else if (inc && bins_ff[i] != COUNT_MAX
                      && (BIN_W'(i) == {1'b0, q_op_i.orth}
                          || BIN_W'(i) == {1'b1, q_op_i.diag})) begin
            bins_in[i] = bins_ff[i] + COUNT_W'(1);
         end
      end
      total_in = total_ff;
      if (clear) begin
         total_in = '0;
      end else if (inc) begin
         total_in = (total_ff >= TOTAL_MAX - TOTAL_W'(1)) ? TOTAL_MAX
                                                          : total_ff + TOTAL_W'(2);
      end
      rd_idx_in = load ? rd_idx_ff + BIN_W'(1) : rd_idx_ff;
      rsp_valid_in = load || (rsp_valid_ff && !rsp_pop_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_RUN;
         bins_ff <= '{default: '0};
         total_ff <= '0;
         rd_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bins_ff <= bins_in;
         total_ff <= total_in;
         rd_idx_ff <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_bin_ff <= rd_idx_ff;
         rsp_count_ff <= bins_ff[rd_idx_ff];
         rsp_total_ff <= total_ff;
         rsp_last_ff <= rd_idx_ff == BIN_W'(BIN_COUNT - 1);
      end
   end

   assign rsp_valid_o = rsp_valid_ff;
   assign rsp_bin_o = rsp_bin_ff;
   assign rsp_count_o = rsp_count_ff;
   assign rsp_total_o = rsp_total_ff;
   assign rsp_last_o = rsp_last_ff;

endmodule

// ----- src/orthogonal_lbp_histogram_unit.sv -----
// Flow: accepted pixels are registered, queued and popped into the histogram; the frame's last
// entry starts the readout, one bin per cycle while results are popped. Throughput: one pixel
// per cycle while req_full is low; the line buffer takes one read and one write a cycle and
// the back end retires one queue entry a cycle outside readout. The 32-bin readout stalls the
// histogram, and result stalls draw it out, while a 4-entry queue absorbs pixels.
// Reset: clears position counters, histogram, code total and queue; width and height return
// to 640 and 480; line buffer contents are left as they are.
module orthogonal_lbp_histogram_unit
   import olbp_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [PIXEL_W-1:0]     req_pixel,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [BIN_W-1:0]       rsp_bin,
   output logic [COUNT_W-1:0]     rsp_count,
   output logic [TOTAL_W-1:0]     rsp_total,
   output logic                   rsp_last,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int W_LAST_RESET = (IMAGE_WIDTH_RESET < MIN_SIZE) ? MIN_SIZE - 1 :
                                 (IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH - 1 :
                                 IMAGE_WIDTH_RESET - 1;
   localparam int H_LAST_RESET = (IMAGE_HEIGHT_RESET < MIN_SIZE) ? MIN_SIZE - 1 :
                                 (IMAGE_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT - 1 :
                                 IMAGE_HEIGHT_RESET - 1;

   logic [COL_W-1:0]          w_last_ff, w_last_in;
   logic [ROW_W-1:0]          h_last_ff, h_last_in;
   logic [IMAGE_WIDTH_W-1:0]  wr_width;
   logic [IMAGE_HEIGHT_W-1:0] wr_height;
   logic                      q_push;
   hist_op_type               q_op_in;
   hist_op_type               q_op;
   logic                      q_pop;
   logic                      q_empty;
   logic [QCNT_W-1:0]         q_count;
   logic                      rsp_valid;

   always_comb begin
      wr_width = csr_wdata[IMAGE_WIDTH_W-1:0];
      wr_height = csr_wdata[IMAGE_HEIGHT_W-1:0];
      w_last_in = w_last_ff;
      h_last_in = h_last_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               if (32'(wr_width) < 32'(MIN_SIZE)) begin
                  w_last_in = COL_W'(MIN_SIZE - 1);
               end else if (32'(wr_width) > 32'(MAX_WIDTH)) begin
                  w_last_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  w_last_in = COL_W'(32'(wr_width) - 32'd1);
               end
            end
            CSR_IMAGE_HEIGHT: begin
               if (32'(wr_height) < 32'(MIN_SIZE)) begin
                  h_last_in = ROW_W'(MIN_SIZE - 1);
               end else if (32'(wr_height) > 32'(MAX_HEIGHT)) begin
                  h_last_in = ROW_W'(MAX_HEIGHT - 1);
               end else begin
                  h_last_in = ROW_W'(32'(wr_height) - 32'd1);
               end
            end
            default: begin
               w_last_in = w_last_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff <= COL_W'(W_LAST_RESET);
         h_last_ff <= ROW_W'(H_LAST_RESET);
      end else begin
         w_last_ff <= w_last_in;
         h_last_ff <= h_last_in;
      end
   end

   olbp_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push_i    (req_push),
      .pixel_i   (req_pixel),
      .w_last_i  (w_last_ff),
      .h_last_i  (h_last_ff),
      .q_count_i (q_count),
      .full_o    (req_full),
      .q_push_o  (q_push),
      .q_op_o    (q_op_in)
   );

   olbp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (q_push),
      .op_i    (q_op_in),
      .pop_i   (q_pop),
      .op_o    (q_op),
      .empty_o (q_empty),
      .count_o (q_count)
   );

   olbp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_op_i      (q_op),
      .q_empty_i   (q_empty),
      .q_pop_o     (q_pop),
      .rsp_pop_i   (rsp_pop),
      .rsp_valid_o (rsp_valid),
      .rsp_bin_o   (rsp_bin),
      .rsp_count_o (rsp_count),
      .rsp_total_o (rsp_total),
      .rsp_last_o  (rsp_last)
   );

   assign rsp_empty = !rsp_valid;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_count != QCNT_W'(QUEUE_DEPTH) || q_pop))
      else $error("queue overflow");

   a_hold_on_frame_end: assert property (@(posedge clock) disable iff (reset)
      q_pop && q_op.last |=> !q_pop)
      else $error("queue popped during readout");

   a_readout_streams: assert property (@(posedge clock) disable iff (reset)
      rsp_pop && !rsp_empty && !rsp_last |=> !rsp_empty)
      else $error("readout gap");

endmodule
